FILE: rtl/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check a consequent in the same cycle as its antecedent
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cpwm_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// cpwm_pkg
// Types, constants and helpers shared by the charlieplex PWM scanner.
// ------------------------------------------------------------------------
package cpwm_pkg;

  localparam int unsigned PWM_LEVELS = 64;
  localparam int unsigned MAX_PINS   = 8;
  localparam int unsigned LED_SLOTS  = MAX_PINS * (MAX_PINS - 1);

  localparam int unsigned PWM_W    = $clog2(PWM_LEVELS);
  localparam int unsigned PIN_W    = $clog2(MAX_PINS);
  localparam int unsigned SLOT_W   = $clog2(LED_SLOTS);
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned LED_W    = 6;
  localparam int unsigned BRIGHT_W = 7;
  localparam int unsigned PROD_W   = 2 * CNT_W;
  localparam int unsigned SUM_W    = ((PWM_W > BRIGHT_W) ? PWM_W : BRIGHT_W) + 1;

  // Command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  typedef struct packed {
    logic                command;
    logic [LED_W-1:0]    led_index;
    logic [BRIGHT_W-1:0] brightness;
  } item_t;

  typedef struct packed {
    logic [MAX_PINS-1:0] drive_enable;
    logic [MAX_PINS-1:0] drive_level;
    logic                end_of_scan;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic tick_start;
    logic write;
    logic read;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_read;
  } ctrl_status_t;

  // Clamp the pin count register to the supported range
  function automatic logic [CNT_W-1:0] pins_in_use(input logic [CNT_W-1:0] raw);
    logic [CNT_W-1:0] n;
    n = raw;
    if (raw < CNT_W'(2)) begin
      n = CNT_W'(2);
    end else if (raw > CNT_W'(MAX_PINS)) begin
      n = CNT_W'(MAX_PINS);
    end
    return n;
  endfunction

endpackage

FILE: rtl/cpwm_ram.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// cpwm_ram
// Generic single-write, single-read RAM with registered read data.
// ------------------------------------------------------------------------
module cpwm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cpwm_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ------------------------------------------------------------------------
// cpwm_ctrl
// Controller: accepts commands and sequences the table reads of a tick.
// ------------------------------------------------------------------------
module cpwm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic                   command_i,
  input  cpwm_pkg::ctrl_status_t status_i,
  output cpwm_pkg::ctrl_cmd_t    cmd_o,
  output logic                   busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_q;
  logic [1:0] state_d;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (command_i == cpwm_pkg::CMD_SET) begin
            cmd_o.write = 1'b1;
          end else begin
            cmd_o.tick_start = 1'b1;
            state_d          = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        if (status_i.last_read) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd_o), "more than one datapath command at once")
  `ASSERT_NEXT(a_tick_reads, cmd_o.tick_start, cmd_o.read, "tick did not start table reads")
  `ASSERT_NEXT(a_drain_idle, cmd_o.finish, !busy, "controller stayed busy after finish")

endmodule

FILE: rtl/cpwm_dpath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ------------------------------------------------------------------------
// cpwm_dpath
// Datapath: brightness table, scan position and pin pattern builder.
// ------------------------------------------------------------------------
module cpwm_dpath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cpwm_pkg::ctrl_cmd_t                   cmd_i,
  output cpwm_pkg::ctrl_status_t                status_o,
  input  cpwm_pkg::item_t                       item_i,
  input  logic                                  cfg_we_i,
  input  logic [cpwm_pkg::CNT_W-1:0]            cfg_wdata_i,
  output logic                                  strobe,
  output cpwm_pkg::result_t                     result_o
);

  localparam int unsigned PWM_W    = cpwm_pkg::PWM_W;
  localparam int unsigned PIN_W    = cpwm_pkg::PIN_W;
  localparam int unsigned SLOT_W   = cpwm_pkg::SLOT_W;
  localparam int unsigned CNT_W    = cpwm_pkg::CNT_W;
  localparam int unsigned BRIGHT_W = cpwm_pkg::BRIGHT_W;
  localparam int unsigned PROD_W   = cpwm_pkg::PROD_W;
  localparam int unsigned SUM_W    = cpwm_pkg::SUM_W;
  localparam int unsigned NPINS    = cpwm_pkg::MAX_PINS;

  // Step a pin number around the ring of pins in use
  function automatic logic [PIN_W-1:0] next_pin(input logic [PIN_W-1:0] p,
                                                input logic [CNT_W-1:0] n);
    logic [PIN_W-1:0] r;
    if (CNT_W'(p) + CNT_W'(1) == n) begin
      r = '0;
    end else begin
      r = p + PIN_W'(1);
    end
    return r;
  endfunction

  logic [CNT_W-1:0]    pin_cnt_q, pin_cnt_d;
  logic [PWM_W-1:0]    pwm_q, pwm_d;
  logic [PIN_W-1:0]    grp_q, grp_d;
  logic [SLOT_W-1:0]   base_q, base_d;
  logic [PIN_W-1:0]    off_q, off_d;
  logic [PIN_W-1:0]    pin_q, pin_d;
  logic [PIN_W-1:0]    pin_pend_q;
  logic                rd_pend_q;
  logic                vld_pend_q;
  logic [NPINS-1:0]    en_q, en_d;
  logic [NPINS-1:0]    lvl_q, lvl_d;
  logic [cpwm_pkg::LED_SLOTS-1:0] vld_q;
  cpwm_pkg::result_t   result_q, result_d;
  logic                strobe_q;

  logic [CNT_W-1:0]    pin_n;
  logic [PROD_W-1:0]   led_limit;
  logic                ram_we;
  logic [SLOT_W-1:0]   waddr;
  logic [SLOT_W-1:0]   raddr;
  logic [BRIGHT_W-1:0] rdata;
  logic [BRIGHT_W-1:0] bright;
  logic                hit;
  logic [NPINS-1:0]    pin_bit;
  logic                wrap;
  logic                last_grp;

  // Derive pin count, LED count and table write control
  assign pin_n     = cpwm_pkg::pins_in_use(pin_cnt_q);
  assign led_limit = PROD_W'(pin_n) * PROD_W'(pin_n - CNT_W'(1));
  assign waddr     = SLOT_W'(item_i.led_index);
  assign ram_we    = cmd_i.write && (PROD_W'(item_i.led_index) < led_limit);
  assign raddr     = base_q + SLOT_W'(off_q);

  cpwm_ram #(
    .WIDTH (BRIGHT_W),
    .DEPTH (cpwm_pkg::LED_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (item_i.brightness),
    .re_i    (cmd_i.read),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Compare the returned brightness against the PWM counter
  assign bright  = vld_pend_q ? rdata : '0;
  assign hit     = rd_pend_q &&
                   (SUM_W'(pwm_q) + SUM_W'(bright) > SUM_W'(cpwm_pkg::PWM_LEVELS));
  assign pin_bit = NPINS'(1) << pin_pend_q;

  assign wrap     = (pwm_q == PWM_W'(cpwm_pkg::PWM_LEVELS - 1));
  assign last_grp = (CNT_W'(grp_q) + CNT_W'(1) >= pin_n);

  assign status_o.last_read = (CNT_W'(off_q) + CNT_W'(2) == pin_n);

  // Next-state logic for scan position, pattern and result
  always_comb begin
    pin_cnt_d = pin_cnt_q;
    pwm_d     = pwm_q;
    grp_d     = grp_q;
    base_d    = base_q;
    off_d     = off_q;
    pin_d     = pin_q;
    en_d      = en_q;
    lvl_d     = lvl_q;
    result_d  = result_q;

    // accumulate lit pins as read data returns
    if (hit) begin
      en_d  = en_q | pin_bit;
      lvl_d = lvl_q | pin_bit;
    end

    // open a tick with the common pin driven low
    if (cmd_i.tick_start) begin
      en_d  = NPINS'(1) << grp_q;
      lvl_d = '0;
      off_d = '0;
      pin_d = next_pin(grp_q, pin_n);
    end

    // advance to the next LED of the group
    if (cmd_i.read) begin
      off_d = off_q + PIN_W'(1);
      pin_d = next_pin(pin_q, pin_n);
    end

    // publish the pattern and move the scan position
    if (cmd_i.finish) begin
      result_d.drive_enable = wrap ? '0 : en_d;
      result_d.drive_level  = wrap ? '0 : lvl_d;
      result_d.end_of_scan  = wrap && last_grp;
      if (wrap) begin
        pwm_d = '0;
        if (last_grp) begin
          grp_d  = '0;
          base_d = '0;
        end else begin
          grp_d  = grp_q + PIN_W'(1);
          base_d = base_q + SLOT_W'(pin_n - CNT_W'(1));
        end
      end else begin
        pwm_d = pwm_q + PWM_W'(1);
      end
    end

    // restart the scan on a pin count write
    if (cfg_we_i) begin
      pin_cnt_d = cfg_wdata_i;
      pwm_d     = '0;
      grp_d     = '0;
      base_d    = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_cnt_q <= CNT_W'(NPINS);
      pwm_q     <= '0;
      grp_q     <= '0;
      base_q    <= '0;
      rd_pend_q <= 1'b0;
      strobe_q  <= 1'b0;
      vld_q     <= '0;
    end else begin
      pin_cnt_q <= pin_cnt_d;
      pwm_q     <= pwm_d;
      grp_q     <= grp_d;
      base_q    <= base_d;
      rd_pend_q <= cmd_i.read;
      strobe_q  <= cmd_i.finish;
      if (ram_we) begin
        vld_q[waddr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    off_q    <= off_d;
    pin_q    <= pin_d;
    en_q     <= en_d;
    lvl_q    <= lvl_d;
    result_q <= result_d;
    if (cmd_i.read) begin
      pin_pend_q <= pin_q;
      vld_pend_q <= vld_q[raddr];
    end
  end

  assign strobe   = strobe_q;
  assign result_o = result_q;

  `ASSERT_IMPL(a_strobe_src, strobe, $past(cmd_i.finish), "result strobe without a finish")
  `ASSERT_IMPL(a_eos_dark, strobe && result_o.end_of_scan, result_o.drive_enable == '0,
               "end of scan with pins driven")
  `ASSERT_ALWAYS(a_grp_range, CNT_W'(grp_q) < pin_n, "group index beyond pin count")

endmodule

FILE: rtl/charlieplex_pwm_scanner_unit.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// charlieplex_pwm_scanner_unit
// Charlieplexed LED PWM scanner: n tristate pins drive n*(n-1) LEDs.
// ------------------------------------------------------------------------
// A set command writes the LED's brightness straight into the table;
// it gives no result and busy stays low. A tick command raises busy
// while the controller reads the group's n-1 brightness values (n =
// pins in use, 2 to 8) one per cycle through the table's single read
// port, then closes the pattern. The pin pattern appears on result_o
// for exactly one cycle with strobe high, in the first cycle busy is
// low again; the next command is taken at the end of that cycle at the
// earliest. Results cannot be held off: capture them when strobe is
// high. Reset clears the table at once through per-entry valid bits,
// with no clearing pass. Writing the pin count restarts the scan at
// group 0.
module charlieplex_pwm_scanner_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  cpwm_pkg::item_t                   item_i,
  output logic                              strobe,
  output cpwm_pkg::result_t                 result_o,
  input  logic                              cfg_we_i,
  input  logic [cpwm_pkg::CNT_W-1:0]        cfg_wdata_i
);

  cpwm_pkg::ctrl_cmd_t    cmd;
  cpwm_pkg::ctrl_status_t status;

  // Sequence commands
  cpwm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (item_i.command),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy      (busy)
  );

  // Build pin patterns
  cpwm_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .strobe      (strobe),
    .result_o    (result_o)
  );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb: charlieplex PWM scanner testbench
// Drives set and tick commands into charlieplex_pwm_scanner_unit over a
// series of pin-count settings. A scoreboard class predicts every tick's
// pin pattern from its own copy of the brightness table and scan position.
// Each strobed result is compared field by field with the oldest
// prediction. The sender idles at random between transactions.
// ------------------------------------------------------------------------
module tb;
  import cpwm_pkg::*;

  localparam int unsigned CLK_PERIOD    = 20;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_ITEMS  = 1150;
  localparam int unsigned MAX_GAP       = 13;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned PLAN_LEN      = 13;

  // Scoreboard: predicts pin patterns and checks strobed results
  class pattern_board;
    bit [BRIGHT_W-1:0] level_tab [LED_SLOTS];
    int unsigned       pwm_pos;
    int unsigned       group_sel;
    int unsigned       base_slot;
    bit [CNT_W-1:0]    pin_reg;
    result_t           expected_q [$];
    int unsigned       n_ticks;
    int unsigned       n_sets;
    int unsigned       n_dropped;
    int unsigned       n_scans;
    int unsigned       n_checked;
    int unsigned       n_mismatch;
    int unsigned       n_unexpected;

    function void restart();
      pwm_pos   = 0;
      group_sel = 0;
      base_slot = 0;
    endfunction

    function void power_on();
      foreach (level_tab[k]) level_tab[k] = '0;
      pin_reg = CNT_W'(MAX_PINS);
      restart();
    endfunction

    // Clamp the register to the range of pins the block supports
    function int unsigned pins_active();
      if (pin_reg < 2) return 2;
      if (pin_reg > MAX_PINS) return MAX_PINS;
      return pin_reg;
    endfunction

    function void load_pins(bit [CNT_W-1:0] value);
      pin_reg = value;
      restart();
    endfunction

    // Note an accepted transaction; ticks queue their predicted pattern
    function void note_item(item_t it);
      int unsigned n;
      int unsigned i;
      int unsigned pin;
      int unsigned slot;
      int unsigned lvl;
      result_t     r;
      n = pins_active();
      if (it.command == CMD_SET) begin
        if (it.led_index < n * (n - 1)) begin
          level_tab[it.led_index] = it.brightness;
          n_sets++;
        end else begin
          n_dropped++;
        end
        return;
      end
      if (group_sel >= n) restart();
      r = '0;
      r.drive_enable[group_sel] = 1'b1;
      for (i = 1; i < n; i++) begin
        pin  = (group_sel + i) % n;
        slot = base_slot + i - 1;
        lvl  = (slot < LED_SLOTS) ? level_tab[slot] : 0;
        if (pwm_pos + lvl > PWM_LEVELS) begin
          r.drive_enable[pin] = 1'b1;
          r.drive_level[pin]  = 1'b1;
        end
      end
      // Wrap the counter: float every pin and move to the next group
      pwm_pos++;
      if (pwm_pos >= PWM_LEVELS) begin
        r.drive_enable = '0;
        r.drive_level  = '0;
        pwm_pos        = 0;
        group_sel++;
        base_slot += n - 1;
        if (group_sel >= n) begin
          restart();
          r.end_of_scan = 1'b1;
          n_scans++;
        end
      end
      n_ticks++;
      expected_q.push_back(r);
    endfunction

    // Compare a strobed result with the oldest prediction
    function void check_pattern(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        n_unexpected++;
        if (n_mismatch + n_unexpected <= REPORT_LIMIT)
          $display("%0t: unexpected result en=%02h lvl=%02h eos=%0b", $time,
                   got.drive_enable, got.drive_level, got.end_of_scan);
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.drive_enable !== want.drive_enable || got.drive_level !== want.drive_level ||
          got.end_of_scan !== want.end_of_scan) begin
        n_mismatch++;
        if (n_mismatch + n_unexpected <= REPORT_LIMIT)
          $display("%0t: mismatch exp en=%02h lvl=%02h eos=%0b got en=%02h lvl=%02h eos=%0b",
                   $time, want.drive_enable, want.drive_level, want.end_of_scan,
                   got.drive_enable, got.drive_level, got.end_of_scan);
      end
    endfunction

    function int unsigned failures();
      return n_mismatch + n_unexpected + expected_q.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  item_t            item_i      = '0;
  logic             strobe;
  result_t          result_o;
  logic             cfg_we_i    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  pattern_board board = new;
  bit           no_idle    = 1'b0;
  int unsigned  n_settings = 0;
  int unsigned  cycle_cnt  = 0;

  charlieplex_pwm_scanner_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .strobe      (strobe),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  // Capture every strobed result
  always @(posedge clk_i) begin
    if (rst_ni && strobe) begin
      board.check_pattern(result_o);
    end
  end

  // Drive one transaction after a random gap and hold until accepted
  task automatic send_item(item_t it);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    board.note_item(it);
  endtask

  // Drop start and wait until every predicted pattern has arrived
  task automatic quiesce();
    start <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_pins(bit [CNT_W-1:0] value);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.load_pins(value);
    n_settings++;
  endtask

  // Tick with random don't-care fields
  function automatic item_t make_tick();
    item_t it;
    it.command    = CMD_TICK;
    it.led_index  = LED_W'($urandom_range(0, 63));
    it.brightness = BRIGHT_W'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic item_t make_set(int unsigned led, int unsigned lvl);
    item_t it;
    it.command    = CMD_SET;
    it.led_index  = LED_W'(led);
    it.brightness = BRIGHT_W'(lvl);
    return it;
  endfunction

  // Favor the edges of the PWM range
  function automatic int unsigned pick_level();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return PWM_LEVELS;
      2: return PWM_LEVELS + 1;
      3: return 127;
      4: return 1;
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  // Mostly valid LED numbers, some past the end of the table
  function automatic int unsigned pick_led(int unsigned n);
    if ($urandom_range(0, 7) == 0) return $urandom_range(n * (n - 1), 63);
    return $urandom_range(0, n * (n - 1) - 1);
  endfunction

  // Stimulus
  initial begin
    int unsigned cfg_plan [PLAN_LEN] = '{1, 3, 9, 2, 4, 15, 5, 0, 6, 8, 7, 2, 3};
    int unsigned sent;
    int unsigned plan_pos;
    int unsigned n;
    int unsigned target;
    int unsigned phase_cnt;
    int unsigned run_len;

    board.power_on();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: dark table after reset, extremes of brightness and index
    send_item(make_tick());
    send_item(make_set(0, PWM_LEVELS));
    send_item(make_set(1, 127));
    send_item(make_set(6, PWM_LEVELS + 1));
    send_item(make_set(LED_SLOTS - 1, 1));
    send_item(make_set(LED_SLOTS, 127));
    send_item(make_set(63, 127));
    send_item(make_set(2, 0));
    send_item(make_tick());
    send_item(make_tick());
    // Fewest pins: index 2 is past the end
    write_pins(2);
    send_item(make_tick());
    send_item(make_set(2, 127));
    send_item(make_set(1, PWM_LEVELS));
    send_item(make_tick());
    send_item(make_tick());
    // Out-of-range pin counts clamp both ways
    write_pins(0);
    send_item(make_tick());
    send_item(make_set(0, 127));
    send_item(make_tick());
    write_pins(15);
    send_item(make_tick());
    send_item(make_set(LED_SLOTS - 1, PWM_LEVELS));
    send_item(make_tick());
    write_pins(1);
    send_item(make_tick());
    send_item(make_tick());

    // Random: per pin-count phase, runs of ticks with bursts of writes
    sent     = 0;
    plan_pos = 0;
    while (sent < RANDOM_ITEMS) begin
      write_pins(CNT_W'(cfg_plan[plan_pos % PLAN_LEN]));
      n         = board.pins_active();
      target    = (n <= 3) ? PWM_LEVELS * n + 40 : 120;
      phase_cnt = 0;
      no_idle   = ($urandom_range(0, 3) == 0);
      while (phase_cnt < target && sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 9) < 4) begin
          run_len = $urandom_range(1, 6);
          repeat (run_len) send_item(make_set(pick_led(n), pick_level()));
        end else begin
          run_len = $urandom_range(1, 40);
          repeat (run_len) send_item(make_tick());
        end
        phase_cnt += run_len;
        sent      += run_len;
        if ($urandom_range(0, 5) == 0) no_idle = !no_idle;
      end
      plan_pos++;
    end

    // Drain and report
    quiesce();
    $display("covered %0d ticks, %0d brightness writes, %0d ignored writes, %0d full scans",
             board.n_ticks, board.n_sets, board.n_dropped, board.n_scans);
    $display("over %0d pin-count settings; %0d results checked, %0d bad, %0d left over",
             n_settings, board.n_checked, board.n_mismatch + board.n_unexpected,
             board.expected_q.size());
    if (board.failures() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
